// ----- rtl/core/call_stack_exclusive_time_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Call stack exclusive time unit: assertion macros
// Shared helpers for concurrent checks, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CALL_STACK_EXCLUSIVE_TIME_UNIT_ASSERT_SVH
`define CALL_STACK_EXCLUSIVE_TIME_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CSET_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define CSET_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/cset_pkg.sv -----
// ---------------------------------------------------------------------------
// cset_pkg
// Types and constants shared by the call stack exclusive time unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cset_pkg;

  localparam int TIME_BITS     = 32;
  localparam int FUNC_ID_W     = 7;
  localparam int MAX_FUNCTIONS = 1 << FUNC_ID_W;
  localparam int CFG_W         = 8;
  localparam int LEVEL_W       = 7;
  localparam logic [CFG_W-1:0] NUM_FUNCTIONS_RST = CFG_W'(MAX_FUNCTIONS);

  typedef enum logic {
    OP_START = 1'b0,
    OP_END   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OVERFLOW    = 3'd1,
    ST_UNDERFLOW   = 3'd2,
    ST_ID_RANGE    = 3'd3,
    ST_ID_MISMATCH = 3'd4,
    ST_TIME_BACK   = 3'd5
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [FUNC_ID_W-1:0] func_id;
    logic [TIME_BITS-1:0] event_time;
  } event_t;

  typedef struct packed {
    logic                 updated;
    logic [FUNC_ID_W-1:0] updated_id;
    logic [TIME_BITS-1:0] exclusive_total;
    status_t              status;
    logic [LEVEL_W-1:0]   stack_level;
  } result_t;

  // One stack frame: function id and the time it started or resumed.
  typedef struct packed {
    logic [FUNC_ID_W-1:0] id;
    logic [TIME_BITS-1:0] resume;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_cmd_t;

  // Credit to apply to one function's total.
  typedef struct packed {
    logic                 upd;
    logic [FUNC_ID_W-1:0] id;
    logic [TIME_BITS-1:0] span;
    logic                 inc;
  } credit_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/cset_ram.sv -----
// ---------------------------------------------------------------------------
// cset_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ---------------------------------------------------------------------------
`default_nettype none

module cset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cset_cell.sv -----
// ---------------------------------------------------------------------------
// cset_cell
// One stack frame slot; shifts down on push, up on pop.
// ---------------------------------------------------------------------------
`default_nettype none

module cset_cell (
  input  wire logic                clk,
  input  wire cset_pkg::stack_cmd_t cmd,
  input  wire cset_pkg::frame_t    push_in,
  input  wire cset_pkg::frame_t    pop_in,
  output cset_pkg::frame_t         q
);

  import cset_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      q <= push_in;
    end else if (cmd.pop) begin
      q <= pop_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cset_credit.sv -----
// ---------------------------------------------------------------------------
// cset_credit
// Totals table with read-modify-write: read on load, saturating add, write on
// advance. Last write is bypassed to the following read.
// ---------------------------------------------------------------------------
`default_nettype none

module cset_credit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire cset_pkg::credit_req_t  req,
  input  wire logic                   advance,
  output logic [cset_pkg::TIME_BITS-1:0] total
);

  import cset_pkg::*;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  logic [MAX_FUNCTIONS-1:0] ent_valid;
  credit_req_t              s1;
  logic                     s1_ent_v;
  logic                     lw_v;
  logic [FUNC_ID_W-1:0]     lw_id;
  logic [TIME_BITS-1:0]     lw_val;
  logic [TIME_BITS-1:0]     rdata;
  logic [TIME_BITS-1:0]     old;
  logic [TIME_BITS+1:0]     sum;
  logic                     wr;

  assign wr = advance && s1.upd;

  cset_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_FUNCTIONS)
  ) u_totals (
    .clk   (clk),
    .we    (wr),
    .waddr (s1.id),
    .wdata (total),
    .re    (load && req.upd),
    .raddr (req.id),
    .rdata (rdata)
  );

  // Capture the request and whether its entry was ever written.
  always_ff @(posedge clk) begin
    if (load) begin
      s1       <= req;
      s1_ent_v <= ent_valid[req.id];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      lw_v      <= 1'b0;
    end else if (wr) begin
      ent_valid[s1.id] <= 1'b1;
      lw_v             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      lw_id  <= s1.id;
      lw_val <= total;
    end
  end

  always_comb begin
    if (lw_v && (lw_id == s1.id)) begin
      old = lw_val;
    end else if (s1_ent_v) begin
      old = rdata;
    end else begin
      old = '0;
    end
    sum = {2'b00, old} + {2'b00, s1.span} + {{(TIME_BITS+1){1'b0}}, s1.inc};
    // Clamp at the top of the time range.
    total = (sum[TIME_BITS+1:TIME_BITS] != 2'b00) ? TIME_MAX : sum[TIME_BITS-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/call_stack_exclusive_time_unit.sv -----
// ---------------------------------------------------------------------------
// call_stack_exclusive_time_unit
// Call-trace profiler: per-function exclusive time from start/end events.
// ---------------------------------------------------------------------------
// Takes one trace event per cycle and returns exactly one result per event,
// registered in turn by the accept edge, the credit stage and the output
// register. The call stack is a chain of STACK_DEPTH frame cells whose top
// sits in cell 0, so every check and push/pop finishes in the accept cycle
// and the next event sees the updated stack at once. The per-function totals
// live in a RAM; the read-modify-write spans the accept edge and the credit
// stage, and the last write is bypassed so back-to-back credits to the same
// id stay exact. Totals read as zero until first written (one valid flop per
// id, cleared by reset), so no clearing pass is needed after reset. The input
// stalls only while the credit stage holds an event behind a stalled output.
// num_functions is written through the cfg channel, which is always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module call_stack_exclusive_time_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cset_pkg::event_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cset_pkg::result_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cset_pkg::CFG_W-1:0]    cfg_data
);

  import cset_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Configuration
  logic [CFG_W-1:0] num_functions;

  // Stack chain and pointer
  frame_t        frames [STACK_DEPTH];
  frame_t        top;
  frame_t        new_frame;
  frame_t        resumed_frame;
  stack_cmd_t    cmd;
  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] sp_next;

  // Decode of the event at the input
  logic          accept;
  logic          empty;
  logic          full;
  logic          id_bad;
  logic          time_back;
  logic          do_push;
  logic          do_pop;
  status_t       status;
  credit_req_t   req;
  logic [TIME_BITS-1:0] resume_time;

  // Credit stage
  logic          s1_v;
  logic          s1_adv;
  result_t       s1_res;
  logic [TIME_BITS-1:0] new_total;
  result_t       out_data_next;

  // Assertion helpers
  logic          out_flagged;
  logic          out_clean;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_functions <= NUM_FUNCTIONS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_functions <= cfg_data;
    end
  end

  // Handshake: the credit stage moves on whenever the output register is
  // free or being drained; hold the input only when the stage is stuck.
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_v && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign top    = frames[0];
  assign empty  = (sp == '0);
  assign full   = (sp == SP_W'(STACK_DEPTH));
  assign id_bad = ({1'b0, in_data.func_id} >= num_functions) ||
                  (int'(in_data.func_id) >= MAX_FUNCTIONS);
  assign time_back = !empty && (top.resume > in_data.event_time);

  // Checks in priority order; a flagged event leaves all state alone.
  always_comb begin
    status  = ST_OK;
    do_push = 1'b0;
    do_pop  = 1'b0;
    req.upd = 1'b0;
    req.id  = '0;
    if (id_bad) begin
      status = ST_ID_RANGE;
    end else if ((in_data.op == OP_START) && full) begin
      status = ST_OVERFLOW;
    end else if ((in_data.op == OP_END) && empty) begin
      status = ST_UNDERFLOW;
    end else if (time_back) begin
      status = ST_TIME_BACK;
    end else if (in_data.op == OP_START) begin
      // Credit the caller on top, then push.
      do_push = 1'b1;
      if (!empty) begin
        req.upd = 1'b1;
        req.id  = top.id;
      end
    end else begin
      // Pop and credit the ending id, even on a mismatch.
      do_pop  = 1'b1;
      req.upd = 1'b1;
      req.id  = in_data.func_id;
      if (top.id != in_data.func_id) begin
        status = ST_ID_MISMATCH;
      end
    end
    req.span = in_data.event_time - top.resume;
    req.inc  = (in_data.op == OP_END);
  end

  always_comb begin
    if (do_push) begin
      sp_next = sp + 1'b1;
    end else if (do_pop) begin
      sp_next = sp - 1'b1;
    end else begin
      sp_next = sp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (accept) begin
      sp <= sp_next;
    end
  end

  // Caller resumes one tick after the end; clamp at the top of time.
  assign resume_time = (in_data.event_time == TIME_MAX) ? TIME_MAX
                                                        : in_data.event_time + 1'b1;

  assign new_frame.id         = in_data.func_id;
  assign new_frame.resume     = in_data.event_time;
  assign resumed_frame.id     = frames[1].id;
  assign resumed_frame.resume = resume_time;

  assign cmd.push = accept && do_push;
  assign cmd.pop  = accept && do_pop;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    frame_t push_src;
    frame_t pop_src;
    if (i == 0) begin : g_top
      assign push_src = new_frame;
      assign pop_src  = resumed_frame;
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      assign push_src = frames[i-1];
      assign pop_src  = frames[i];
    end else begin : g_mid
      assign push_src = frames[i-1];
      assign pop_src  = frames[i+1];
    end
    cset_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .push_in (push_src),
      .pop_in  (pop_src),
      .q       (frames[i])
    );
  end

  // Totals table and saturating add
  cset_credit u_credit (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .req     (req),
    .advance (s1_v && s1_adv),
    .total   (new_total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res.updated         <= req.upd;
      s1_res.updated_id      <= req.id;
      s1_res.exclusive_total <= '0;
      s1_res.status          <= status;
      s1_res.stack_level     <= LEVEL_W'(sp_next);
    end
  end

  // Merge the fresh total into the staged result.
  always_comb begin
    out_data_next                 = s1_res;
    out_data_next.exclusive_total = s1_res.updated ? new_total : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v) begin
      out_data <= out_data_next;
    end
  end

  // Assertions
  assign out_flagged = out_valid && ((out_data.status == ST_ID_RANGE) ||
                                     (out_data.status == ST_OVERFLOW) ||
                                     (out_data.status == ST_UNDERFLOW) ||
                                     (out_data.status == ST_TIME_BACK));
  assign out_clean   = !out_data.updated && (out_data.exclusive_total == '0);

  `include "call_stack_exclusive_time_unit_assert.svh"

  `CSET_ASSERT_SAME(a_sp_bound, 1'b1, sp <= SP_W'(STACK_DEPTH), "stack pointer past depth")
  `CSET_ASSERT_NEXT(a_push_grows, cmd.push, sp == $past(sp) + 1'b1, "push lost")
  `CSET_ASSERT_SAME(a_flag_no_update, out_flagged, out_clean, "flagged event updated a total")

endmodule

`default_nettype wire
